// ===== rtl/rs2d_pkg.sv =====
// Shared types and constants for the 2D range-sum segment tree.
`default_nettype none
package rs2d_pkg;
  localparam int unsigned ROWS_DEF = 64;
  localparam int unsigned COLS_DEF = 64;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned FLD_W = 6;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Classified word passed from front to back.
  typedef struct packed {
    logic             is_query;
    logic             skip;     // set outside grid, or empty query
    logic [FLD_W-1:0] r0;       // set: row; query: first row
    logic [FLD_W-1:0] r1;       // query: last row (clamped)
    logic [FLD_W-1:0] c0;
    logic [FLD_W-1:0] c1;
    logic [VAL_W-1:0] value;
  } op_t;
endpackage
`default_nettype wire

// ===== rtl/rs2d_front.sv =====
// Front end: accepts input words, clamps ranges, flags no-op items.
`default_nettype none
module rs2d_front #(
  parameter int unsigned ROWS = rs2d_pkg::ROWS_DEF,
  parameter int unsigned COLS = rs2d_pkg::COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       cmd,
  input  wire logic [rs2d_pkg::FLD_W-1:0] point_row,
  input  wire logic [rs2d_pkg::FLD_W-1:0] point_col,
  input  wire logic signed [rs2d_pkg::VAL_W-1:0] value,
  input  wire logic [rs2d_pkg::FLD_W-1:0] row_lo,
  input  wire logic [rs2d_pkg::FLD_W-1:0] row_hi,
  input  wire logic [rs2d_pkg::FLD_W-1:0] col_lo,
  input  wire logic [rs2d_pkg::FLD_W-1:0] col_hi,
  output rs2d_pkg::op_t                   op,
  output logic                            op_valid,
  input  wire logic                       op_take
);
  localparam int unsigned DEPTH = 2;
  localparam int unsigned FW = rs2d_pkg::FLD_W;
  localparam logic [10:0] RMAX = 11'(ROWS - 1);
  localparam logic [10:0] CMAX = 11'(COLS - 1);

  rs2d_pkg::op_t q [DEPTH];
  logic          wp, rp;
  logic [1:0]    cnt;
  rs2d_pkg::op_t cls;
  logic [10:0]   r1c, c1c;

  always_comb begin
    r1c = ({5'd0, row_hi} > RMAX) ? RMAX : {5'd0, row_hi};
    c1c = ({5'd0, col_hi} > CMAX) ? CMAX : {5'd0, col_hi};
    cls.is_query = (cmd == rs2d_pkg::CMD_QUERY);
    cls.value    = value;
    if (cls.is_query) begin
      cls.r0   = row_lo;
      cls.r1   = r1c[FW-1:0];
      cls.c0   = col_lo;
      cls.c1   = c1c[FW-1:0];
      cls.skip = ({5'd0, row_lo} > r1c) || ({5'd0, col_lo} > c1c);
    end else begin
      cls.r0   = point_row;
      cls.r1   = '0;
      cls.c0   = point_col;
      cls.c1   = '0;
      cls.skip = ({5'd0, point_row} > RMAX) || ({5'd0, point_col} > CMAX);
    end
  end

  assign full     = (cnt == 2'(DEPTH));
  assign op_valid = (cnt != 2'd0);
  assign op       = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) q[wp] <= cls;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (op_take && op_valid) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(op_take && op_valid);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rs2d_back.sv =====
// Back end: node memory, clear pass, set and query sequencer, result register.
`default_nettype none
module rs2d_back #(
  parameter int unsigned ROWS = rs2d_pkg::ROWS_DEF,
  parameter int unsigned COLS = rs2d_pkg::COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rs2d_pkg::op_t     op,
  input  wire logic              op_valid,
  output logic                   op_take,
  output logic                   empty,
  input  wire logic              pop,
  output logic signed [rs2d_pkg::SUM_W-1:0] rect_sum
);
  localparam int unsigned RB = (ROWS <= 1) ? 0 : $clog2(ROWS);
  localparam int unsigned CB = (COLS <= 1) ? 0 : $clog2(COLS);
  localparam int unsigned RI = RB + 1;   // node row index width
  localparam int unsigned CI = CB + 1;
  localparam int unsigned AW = RI + CI;
  localparam int unsigned SW = rs2d_pkg::SUM_W;
  localparam int unsigned RW = RI + 1;   // holds span+range bound
  localparam int unsigned CW = CI + 1;
  localparam logic [RW-1:0] RSPAN = RW'(1) << RB;
  localparam logic [CW-1:0] CSPAN = CW'(1) << CB;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LEAF, S_RD0, S_RD1, S_WR,
    S_ROWSTEP, S_QROW, S_QCOL, S_QRD, S_QACC, S_DONE
  } state_t;
  state_t state;

  logic [SW-1:0] mem [2**AW];
  logic [AW-1:0] raddr, waddr;
  logic [SW-1:0] rdata, wdata;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Set walk: row index ri, column index ci; pass 0 = leaf row, 1 = upper rows.
  logic [RI-1:0] ri;
  logic [CI-1:0] ci, leafc;
  logic          rowpass;
  logic [SW-1:0] a;
  // Query walk
  logic [RW-1:0] rlo, rhi;
  logic [CW-1:0] clo, chi, qclo, qchi;
  logic [RI-1:0] qrow;
  logic          rsecond, csecond;
  logic [CI-1:0] qcol;
  logic [SW-1:0] acc;
  logic [AW:0]   clr;
  // result register
  logic          rvalid;
  logic [SW-1:0] rres;

  assign empty    = !rvalid;
  assign rect_sum = rres;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state)
      S_CLR: begin we = 1'b1; waddr = clr[AW-1:0]; end
      S_LEAF: begin
        we = 1'b1; waddr = {ri, ci};
        wdata = SW'(signed'(op.value));
      end
      S_RD0: raddr = rowpass ? {ri[RI-2:0], 1'b0, ci} : {ri, ci[CI-2:0], 1'b0};
      S_RD1: raddr = rowpass ? {ri[RI-2:0], 1'b1, ci} : {ri, ci[CI-2:0], 1'b1};
      S_WR: begin we = 1'b1; waddr = {ri, ci}; wdata = a + rdata; end
      S_QRD: raddr = {qrow, qcol};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && rvalid) rvalid <= 1'b0;
    op_take <= 1'b0;
    if (rst) begin
      state <= S_CLR; clr <= '0; rvalid <= 1'b0; op_take <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(2**AW - 1)) state <= S_IDLE;
        end
        S_IDLE: if (op_valid && !op_take) begin
          if (op.skip) begin
            if (op.is_query) begin
              if (!rvalid || pop) begin
                rres <= '0; rvalid <= 1'b1; op_take <= 1'b1;
              end
            end else op_take <= 1'b1;
          end else if (op.is_query) begin
            if (!rvalid || pop) begin
              rlo <= RSPAN + RW'(op.r0);
              rhi <= RSPAN + RW'(op.r1) + RW'(1);
              qclo <= CSPAN + CW'(op.c0);
              qchi <= CSPAN + CW'(op.c1) + CW'(1);
              acc <= '0; rsecond <= 1'b0;
              state <= S_QROW;
            end
          end else begin
            ri <= RI'(RSPAN) | RI'(op.r0);
            ci <= CI'(CSPAN) | CI'(op.c0);
            leafc <= CI'(CSPAN) | CI'(op.c0);
            rowpass <= 1'b0;
            state <= S_LEAF;
          end
        end
        S_LEAF: begin
          if (CB == 0) begin
            ri <= ri >> 1; rowpass <= 1'b1; state <= S_ROWSTEP;
          end else begin
            ci <= ci >> 1; state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin a <= rdata; state <= S_WR; end
        S_WR: begin
          if (ci > CI'(1) && !rowpass) begin
            ci <= ci >> 1; state <= S_RD0;
          end else if (rowpass && ci > CI'(1)) begin
            ci <= ci >> 1; state <= S_RD0;
          end else begin
            ri <= rowpass ? ri >> 1 : ri >> 1;
            ci <= leafc; rowpass <= 1'b1; state <= S_ROWSTEP;
          end
        end
        S_ROWSTEP: begin
          if (ri == '0) begin
            op_take <= 1'b1; state <= S_DONE;
          end else state <= S_RD0;
        end
        // query: outer row loop picks a node row, inner column loop sums it
        S_QROW: begin
          if (rlo >= rhi) begin
            rres <= acc; rvalid <= 1'b1; op_take <= 1'b1; state <= S_DONE;
          end else if (!rsecond) begin
            rsecond <= 1'b1;
            if (rlo[0]) begin
              qrow <= rlo[RI-1:0]; rlo <= rlo + 1'b1;
              clo <= qclo; chi <= qchi; csecond <= 1'b0; state <= S_QCOL;
            end
          end else begin
            rsecond <= 1'b0;
            if (rhi[0]) begin
              qrow <= RI'(rhi - 1'b1); rhi <= rhi - 1'b1;
              clo <= qclo; chi <= qchi; csecond <= 1'b0; state <= S_QCOL;
            end else begin
              rlo <= rlo >> 1; rhi <= rhi >> 1;
            end
          end
        end
        S_QCOL: begin
          if (clo >= chi) begin
            if (rsecond) state <= S_QROW;
            else begin rlo <= rlo >> 1; rhi <= rhi >> 1; state <= S_QROW; end
          end else if (!csecond) begin
            csecond <= 1'b1;
            if (clo[0]) begin
              qcol <= clo[CI-1:0]; clo <= clo + 1'b1; state <= S_QRD;
            end
          end else begin
            csecond <= 1'b0;
            if (chi[0]) begin
              qcol <= CI'(chi - 1'b1); chi <= chi - 1'b1; state <= S_QRD;
            end else begin
              clo <= clo >> 1; chi <= chi >> 1;
            end
          end
        end
        S_QRD: state <= S_QACC;
        S_QACC: begin
          acc <= acc + rdata;
          // after the high-side node the level is done: move up one level
          if (csecond) state <= S_QCOL;
          else begin
            clo <= clo >> 1; chi <= chi >> 1; state <= S_QCOL;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/range_sum_2d_segment_tree_core.sv =====
// Top level of the 2D range-sum segment tree.
// Usage:
//   Input channel is a queue: drive cmd and its fields, raise push; the
//   word is taken on an edge with push high and full low. cmd 0 sets one
//   cell, cmd 1 asks for the sum over an inclusive rectangle.
//   Result channel is a one-entry register: while empty is low rect_sum
//   holds the sum; it is taken on an edge with pop high. A set gives no
//   result word; a query gives exactly one.
// Structure:
//   A front stage classifies words into a two-deep queue; the back stage
//   walks the node memory with one read port. A set writes the leaf, then
//   updates each upper node by reading its two children and writing their
//   sum; a query walks the tree levels and reads each covering node, and
//   an empty range gives a zero sum without a walk.
// Reset:
//   rst clears the queues, then a clearing pass zeroes all 4*ROWSPAN*COLSPAN
//   nodes, one per cycle; full rises once the front queue holds two words.
//   A stalled receiver keeps a finished sum in the result register; the
//   back end waits at the next query and the front queue fills up.
`default_nettype none
module range_sum_2d_segment_tree_core #(
  parameter int unsigned ROWS = rs2d_pkg::ROWS_DEF,
  parameter int unsigned COLS = rs2d_pkg::COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       cmd,
  input  wire logic [rs2d_pkg::FLD_W-1:0] point_row,
  input  wire logic [rs2d_pkg::FLD_W-1:0] point_col,
  input  wire logic signed [rs2d_pkg::VAL_W-1:0] value,
  input  wire logic [rs2d_pkg::FLD_W-1:0] row_lo,
  input  wire logic [rs2d_pkg::FLD_W-1:0] row_hi,
  input  wire logic [rs2d_pkg::FLD_W-1:0] col_lo,
  input  wire logic [rs2d_pkg::FLD_W-1:0] col_hi,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [rs2d_pkg::SUM_W-1:0] rect_sum
);
  rs2d_pkg::op_t op;
  logic          op_valid, op_take;

  rs2d_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk, .rst, .push, .full, .cmd, .point_row, .point_col, .value,
    .row_lo, .row_hi, .col_lo, .col_hi, .op, .op_valid, .op_take
  );

  rs2d_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk, .rst, .op, .op_valid, .op_take, .empty, .pop, .rect_sum
  );
endmodule
`default_nettype wire
